>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh - shared assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> rtl/dart_pkg.sv
// ---------------------------------------------------------------------------
// dart_pkg - divider and reload timer package
// Widths, register indexes, period select codes and the sequencer states.
// ---------------------------------------------------------------------------
package dart_pkg;

  // default clamp on the cycles one transaction may advance
  localparam int MaxStepCyclesDefault = 64;

  localparam int ElapsedW  = 7;
  localparam int CountW    = 8;
  localparam int CntPreW   = 10;
  // prescaler plus one advance: 1023 + 127 fits in 11 bits
  localparam int CntAccW   = 11;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 8;

  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_RELOAD_VALUE = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_TIMER_ENABLE = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_CLOCK_SELECT = 2'd2;

  // clock select codes
  localparam logic [1:0] SEL_P1024 = 2'b00;
  localparam logic [1:0] SEL_P16   = 2'b01;
  localparam logic [1:0] SEL_P64   = 2'b10;
  localparam logic [1:0] SEL_P256  = 2'b11;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  // counter period in cycles for a clock select code
  function automatic logic [CntAccW-1:0] period_of(logic [1:0] sel);
    logic [CntAccW-1:0] p;
    case (sel)
      SEL_P1024: p = 11'd1024;
      SEL_P16:   p = 11'd16;
      SEL_P64:   p = 11'd64;
      SEL_P256:  p = 11'd256;
      default:   p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/divider_and_reload_timer_top.sv
// An accepted transaction is loaded, then the sequencer steps through the n counter
// ticks it causes (one subtract-and-compare per cycle) and, once the output is free,
// registers the result; no new transaction is taken before then. Usually n is 0 to 4, up to 67
// after the period is shortened. Divider update is done in the load cycle.
// Reset (rst, synchronous) clears the configuration registers, prescalers, counts and out_valid.
// ---------------------------------------------------------------------------
// divider_and_reload_timer_top - divider and reloading timer counter
// Advances a free-running divider and a prescaled, reloading counter by the
// elapsed cycles of each transaction and reports both plus an overflow flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module divider_and_reload_timer_top import dart_pkg::*; #(
  parameter int MAX_STEP_CYCLES = MaxStepCyclesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ElapsedW-1:0]  elapsed_cycles,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CountW-1:0]    divider_value,
  output logic [CountW-1:0]    counter_value,
  output logic                 timer_irq
);

  // clamp limit, capped at what the input field can carry
  localparam int SatInt = (MAX_STEP_CYCLES > 127) ? 127 : MAX_STEP_CYCLES;
  localparam logic [ElapsedW-1:0] SatLimit = ElapsedW'(SatInt);

  // configuration registers
  logic [CountW-1:0] reload_value;
  logic              timer_enable;
  logic [1:0]        clock_select;

  // timer state
  logic [CountW-1:0]  div_pre;
  logic [CountW-1:0]  div_cnt;
  logic [CntPreW-1:0] cnt_pre;
  logic [CountW-1:0]  cnt_cnt;

  // working registers of the sequencer
  state_t             state, state_next;
  logic [CntAccW-1:0] acc;
  logic               run_en;
  logic               irq_acc;

  logic               in_take;
  logic               out_free;
  logic               step;
  logic               finish;
  logic [ElapsedW-1:0] amt;
  logic [CountW:0]     div_sum;
  logic [CntAccW-1:0]  period;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value <= '0;
      timer_enable <= 1'b0;
      clock_select <= SEL_P1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELOAD_VALUE: reload_value <= cfg_data;
        REG_TIMER_ENABLE: timer_enable <= cfg_data[0];
        REG_CLOCK_SELECT: clock_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamped advance and divider sum (at most one divider tick per transaction)
  assign amt     = (elapsed_cycles > SatLimit) ? SatLimit : elapsed_cycles;
  assign div_sum = {1'b0, div_pre} + {{(CountW + 1 - ElapsedW){1'b0}}, amt};
  assign period  = period_of(clock_select);

  // shared compare: another whole period left in the accumulator
  assign step     = run_en && (acc >= period);
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_CALC) && !step && out_free;
  assign in_take  = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CALC;
      S_CALC:  if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_CALC:  in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // load, iterate and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      div_pre <= '0;
      div_cnt <= '0;
      cnt_pre <= '0;
      cnt_cnt <= '0;
    end else if (in_take) begin
      div_pre <= div_sum[CountW-1:0];
      div_cnt <= div_cnt + CountW'(div_sum[CountW]);
    end else if (state == S_CALC) begin
      if (step) begin
        if (cnt_cnt == COUNT_MAX) begin
          cnt_cnt <= reload_value;
        end else begin
          cnt_cnt <= cnt_cnt + 8'd1;
        end
      end else begin
        // below one period (or left unchanged when disabled), so the remainder fits the prescaler
        cnt_pre <= acc[CntPreW-1:0];
      end
    end
  end

  // accumulator and overflow flag
  always_ff @(posedge clk) begin
    if (in_take) begin
      run_en  <= timer_enable;
      irq_acc <= 1'b0;
      if (timer_enable) begin
        acc <= {1'b0, cnt_pre} + {{(CntAccW - ElapsedW){1'b0}}, amt};
      end else begin
        acc <= {1'b0, cnt_pre};
      end
    end else if (state == S_CALC && step) begin
      acc <= acc - period;
      if (cnt_cnt == COUNT_MAX) begin
        irq_acc <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      divider_value <= div_cnt;
      counter_value <= cnt_cnt;
      timer_irq     <= irq_acc;
    end
  end

  // checks
  `ASSERT_NEXT(a_take_starts_calc, clk, rst, in_take, state == S_CALC)
  `ASSERT_NEXT(a_step_keeps_calc, clk, rst, state == S_CALC && step, state == S_CALC)
  `ASSERT_IMPL(a_irq_needs_enable, clk, rst, state == S_CALC && irq_acc, run_en)
  `ASSERT_IMPL(a_finish_output_free, clk, rst, finish, !out_valid || !out_stall)

endmodule
